>>> design/gwrc_pkg.sv
// gwrc_pkg: shared types, constants and stick helpers for the gamepad to wii report converter
// no dependencies; used by every module of the block

package gwrc_pkg;

  // accelerometer values
  localparam logic [9:0] ACC_REST    = 10'h200;
  localparam logic [9:0] ACC_FAKE_XY = 10'h208;
  localparam logic [9:0] ACC_FAKE_Z  = 10'h27C;

  // register reset values
  localparam logic [3:0]  HOLD_FRAMES_RST   = 4'd10;
  localparam logic [14:0] DEADZONE_RST      = 15'd2048;
  localparam logic [7:0]  NUN_C_THRESH_RST  = 8'd127;
  localparam logic [7:0]  CLS_TRIG_THRESH_RST = 8'd32;

  // led flash counts requested on a mode switch
  localparam logic [1:0] FLASH_NONE    = 2'd0;
  localparam logic [1:0] FLASH_REMOTE  = 2'd1;
  localparam logic [1:0] FLASH_NUNCHUK = 2'd2;
  localparam logic [1:0] FLASH_CLASSIC = 2'd3;

  // mode numbers as reported
  localparam logic [1:0] MODE_NUM_REMOTE  = 2'd0;
  localparam logic [1:0] MODE_NUM_NUNCHUK = 2'd1;
  localparam logic [1:0] MODE_NUM_CLASSIC = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_FRAMES     = 2'd0,
    CFG_DEADZONE        = 2'd1,
    CFG_NUN_C_THRESH    = 2'd2,
    CFG_CLS_TRIG_THRESH = 2'd3
  } cfg_idx_e;

  // one-hot mode state
  typedef enum logic [2:0] {
    MODE_REMOTE  = 3'b001,
    MODE_NUNCHUK = 3'b010,
    MODE_CLASSIC = 3'b100
  } mode_e;

  typedef struct packed {
    logic [3:0]  hold_frames;
    logic [14:0] deadzone;
    logic [7:0]  nunchuk_c_threshold;
    logic [7:0]  classic_trigger_threshold;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        buttons;
    logic [3:0]         dpad;
    logic signed [15:0] stick_lx;
    logic signed [15:0] stick_ly;
    logic signed [15:0] stick_rx;
    logic signed [15:0] stick_ry;
    logic [7:0]         trigger_left;
    logic [7:0]         trigger_right;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [10:0]       remote_buttons;
    logic signed [7:0] pointer_x;
    logic signed [7:0] pointer_y;
    logic [29:0]       accel_xyz;
    logic [15:0]       nunchuk_stick;
    logic [1:0]        nunchuk_keys;
    logic [14:0]       classic_keys;
    logic [15:0]       classic_triggers;
    logic [21:0]       classic_sticks;
    logic [4:0]        sideway_latch;
    logic [3:0]        event_flags;
  } out_item_t;

  // stick values derived from one frame, ahead of the mode logic
  typedef struct packed {
    logic [7:0]  left_ptr_x;
    logic [7:0]  left_ptr_y;
    logic [7:0]  right_ptr_x;
    logic [7:0]  right_ptr_y;
    logic [15:0] nun_stick;
    logic [21:0] cls_sticks;
  } axis_t;

  // negate, with the most negative value saturating
  function automatic logic signed [15:0] neg_sat(logic signed [15:0] v);
    neg_sat = (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction

  // magnitude below the deadzone reads as zero
  function automatic logic signed [15:0] dead_zone(logic signed [15:0] v, logic [14:0] d);
    logic signed [16:0] ve;
    logic signed [16:0] de;
    ve = $signed({v[15], v});
    de = $signed({2'b00, d});
    dead_zone = ((ve > -de) && (ve < de)) ? 16'sd0 : v;
  endfunction

  // floor(v / 256) as 8-bit two's complement
  function automatic logic [7:0] to_ptr(logic signed [15:0] v);
    to_ptr = v[15:8];
  endfunction

  // offset binary, centre 128
  function automatic logic [7:0] to_nun(logic signed [15:0] v);
    to_nun = {~v[15], v[14:8]};
  endfunction

  // floor((v*31 + 1048576) / 32768), clamped to 63
  function automatic logic [5:0] to_cls_l(logic signed [15:0] v);
    logic signed [22:0] ve;
    logic signed [22:0] t;
    logic [6:0]         q;
    ve = $signed({{7{v[15]}}, v});
    t  = (ve <<< 5) - ve + 23'sd1048576;
    q  = t[21:15];
    to_cls_l = (q > 7'd63) ? 6'd63 : q[5:0];
  endfunction

  // floor((v*15 + 491520) / 32768), clamped to 30
  function automatic logic [4:0] to_cls_r(logic signed [15:0] v);
    logic signed [20:0] ve;
    logic signed [20:0] t;
    logic [4:0]         q;
    ve = $signed({{5{v[15]}}, v});
    t  = (ve <<< 4) - ve + 21'sd491520;
    q  = t[19:15];
    to_cls_r = (q > 5'd30) ? 5'd30 : q;
  endfunction

endpackage

>>> design/gwrc_cfg_regs.sv
// gwrc_cfg_regs: configuration registers behind the plain write port
// depends on gwrc_pkg

module gwrc_cfg_regs import gwrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HOLD_FRAMES:     cfg_d.hold_frames = cfg_wdata_i[3:0];
        CFG_DEADZONE:        cfg_d.deadzone = cfg_wdata_i[14:0];
        CFG_NUN_C_THRESH:    cfg_d.nunchuk_c_threshold = cfg_wdata_i[7:0];
        CFG_CLS_TRIG_THRESH: cfg_d.classic_trigger_threshold = cfg_wdata_i[7:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_frames               <= HOLD_FRAMES_RST;
      cfg_q.deadzone                  <= DEADZONE_RST;
      cfg_q.nunchuk_c_threshold       <= NUN_C_THRESH_RST;
      cfg_q.classic_trigger_threshold <= CLS_TRIG_THRESH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/gwrc_axis_map.sv
// gwrc_axis_map: stick negation, deadzones and scaling for pointer, nunchuk and classic
// depends on gwrc_pkg

module gwrc_axis_map import gwrc_pkg::*; (
  input  in_item_t    item_i,
  input  logic [14:0] deadzone_i,
  output axis_t       axis_o
);

  logic signed [15:0] ly, ry;
  logic signed [15:0] lx_dz, ly_dz, rx_dz, ry_dz;

  // vertical axes are flipped
  assign ly = neg_sat(item_i.stick_ly);
  assign ry = neg_sat(item_i.stick_ry);

  // deadzone applied per axis
  assign lx_dz = dead_zone(item_i.stick_lx, deadzone_i);
  assign ly_dz = dead_zone(ly, deadzone_i);
  assign rx_dz = dead_zone(item_i.stick_rx, deadzone_i);
  assign ry_dz = dead_zone(ry, deadzone_i);

  // pointer from either stick
  assign axis_o.left_ptr_x  = to_ptr(lx_dz);
  assign axis_o.left_ptr_y  = to_ptr(ly_dz);
  assign axis_o.right_ptr_x = to_ptr(rx_dz);
  assign axis_o.right_ptr_y = to_ptr(ry_dz);

  // nunchuk stick from the left stick
  assign axis_o.nun_stick = {to_nun(lx_dz), to_nun(ly_dz)};

  // classic sticks: left has no deadzone
  assign axis_o.cls_sticks = {to_cls_l(item_i.stick_lx), to_cls_l(ly),
                              to_cls_r(rx_dz), to_cls_r(ry_dz)};

endmodule

>>> design/gwrc_mode_ctrl.sv
// gwrc_mode_ctrl: mode machine, hold counter, sideway latch, fake motion and held extension data
// depends on gwrc_pkg; takes stick values from gwrc_axis_map

module gwrc_mode_ctrl import gwrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  input  axis_t     axis_i,
  output out_item_t res_o
);

  mode_e       mode_q, mode_d;
  logic [3:0]  hold_q, hold_d;
  logic [4:0]  side_q, side_d;
  logic        fake_q, fake_d;
  logic [15:0] nun_stick_q, nun_stick_d;
  logic [1:0]  nun_keys_q, nun_keys_d;
  logic [14:0] cls_keys_q, cls_keys_d;
  logic [15:0] cls_trig_q, cls_trig_d;
  logic [21:0] cls_sticks_q, cls_sticks_d;

  logic        lb, rb, home_in, down_in;
  logic [3:0]  hold_inc;

  assign lb      = item_i.buttons[8];
  assign rb      = item_i.buttons[9];
  assign home_in = item_i.buttons[10];
  assign down_in = item_i.dpad[1];
  assign hold_inc = hold_q + 4'd1;

  // next state and report for one frame
  always_comb begin
    logic       home, down, chome, cdown, both, sw;
    logic [9:0] ax, ay, az;
    logic [7:0] px, py;
    logic [1:0] flash, mode_num;
    logic       rst_ptr, ctr;

    mode_d       = mode_q;
    hold_d       = hold_q;
    side_d       = side_q;
    fake_d       = fake_q;
    nun_stick_d  = nun_stick_q;
    nun_keys_d   = nun_keys_q;
    cls_keys_d   = cls_keys_q;
    cls_trig_d   = cls_trig_q;
    cls_sticks_d = cls_sticks_q;
    home    = home_in;
    down    = down_in;
    chome   = home_in;
    cdown   = down_in;
    ax      = ACC_REST;
    ay      = ACC_REST;
    az      = ACC_REST;
    flash   = FLASH_NONE;
    rst_ptr = 1'b0;
    ctr     = 1'b0;
    px      = axis_i.left_ptr_x;
    py      = axis_i.left_ptr_y;
    both    = 1'b0;

    unique case (mode_q)
      MODE_NUNCHUK: begin
        px = axis_i.right_ptr_x;
        py = axis_i.right_ptr_y;
        nun_stick_d = axis_i.nun_stick;
        nun_keys_d  = {rb, item_i.trigger_left > cfg_i.nunchuk_c_threshold};
        // fake motion burst on lb release
        if (lb) begin
          fake_d = 1'b1;
        end else if (fake_q) begin
          ax = ACC_FAKE_XY;
          ay = ACC_FAKE_XY;
          az = ACC_FAKE_Z;
          fake_d = 1'b0;
          ctr = 1'b1;
        end
        both = home_in && down_in;
      end
      MODE_CLASSIC: begin
        px = axis_i.right_ptr_x;
        py = axis_i.right_ptr_y;
        both = home_in && down_in;
      end
      default: begin
        // sideway latch: home+lb holds it, release toggles orientation
        if (home_in && lb) begin
          home = 1'b0;
          side_d = {4'hF, side_q[0]};
        end else if (side_q[4:1] == 4'hF) begin
          side_d = {4'h0, ~side_q[0]};
        end
        both = home && down_in;
      end
    endcase

    // hold counter
    sw = 1'b0;
    if (!both) begin
      hold_d = 4'd0;
    end else if (hold_inc >= cfg_i.hold_frames) begin
      hold_d = 4'd0;
      sw = 1'b1;
    end else begin
      hold_d = hold_inc;
    end

    // mode switch
    if (sw) begin
      rst_ptr = 1'b1;
      unique case (mode_q)
        MODE_NUNCHUK: begin
          home = 1'b0;
          down = 1'b0;
          mode_d = MODE_CLASSIC;
          flash = FLASH_CLASSIC;
        end
        MODE_CLASSIC: begin
          chome = 1'b0;
          cdown = 1'b0;
          mode_d = MODE_REMOTE;
          flash = FLASH_REMOTE;
        end
        default: begin
          home = 1'b0;
          down = 1'b0;
          mode_d = MODE_NUNCHUK;
          flash = FLASH_NUNCHUK;
        end
      endcase
    end

    // classic extension data
    if (mode_q == MODE_CLASSIC) begin
      cls_keys_d = {item_i.trigger_right > cfg_i.classic_trigger_threshold,
                    item_i.trigger_left > cfg_i.classic_trigger_threshold,
                    rb, lb, item_i.dpad[3], item_i.dpad[2], cdown, item_i.dpad[0],
                    chome, item_i.buttons[7], item_i.buttons[6], item_i.buttons[2],
                    item_i.buttons[3], item_i.buttons[1], item_i.buttons[0]};
      cls_trig_d   = {item_i.trigger_left, item_i.trigger_right};
      cls_sticks_d = axis_i.cls_sticks;
    end

    unique case (mode_d)
      MODE_NUNCHUK: mode_num = MODE_NUM_NUNCHUK;
      MODE_CLASSIC: mode_num = MODE_NUM_CLASSIC;
      default:      mode_num = MODE_NUM_REMOTE;
    endcase

    res_o.mode           = mode_num;
    res_o.remote_buttons = {item_i.dpad[3], item_i.dpad[2], down, item_i.dpad[0],
                            item_i.buttons[3], item_i.buttons[2], home,
                            item_i.buttons[7], item_i.buttons[6],
                            item_i.buttons[1], item_i.buttons[0]};
    res_o.pointer_x        = px;
    res_o.pointer_y        = py;
    res_o.accel_xyz        = {ax, ay, az};
    res_o.nunchuk_stick    = nun_stick_d;
    res_o.nunchuk_keys     = nun_keys_d;
    res_o.classic_keys     = cls_keys_d;
    res_o.classic_triggers = cls_trig_d;
    res_o.classic_sticks   = cls_sticks_d;
    res_o.sideway_latch    = side_d;
    res_o.event_flags      = {ctr, rst_ptr, flash};
  end

  // state moves on each frame handed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_REMOTE;
      hold_q       <= 4'd0;
      side_q       <= 5'd0;
      fake_q       <= 1'b0;
      nun_stick_q  <= 16'd0;
      nun_keys_q   <= 2'd0;
      cls_keys_q   <= 15'd0;
      cls_trig_q   <= 16'd0;
      cls_sticks_q <= 22'd0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      hold_q       <= hold_d;
      side_q       <= side_d;
      fake_q       <= fake_d;
      nun_stick_q  <= nun_stick_d;
      nun_keys_q   <= nun_keys_d;
      cls_keys_q   <= cls_keys_d;
      cls_trig_q   <= cls_trig_d;
      cls_sticks_q <= cls_sticks_d;
    end
  end

endmodule

>>> design/gamepad_to_wii_report_converter.sv
// gamepad_to_wii_report_converter: top level, input register, result register and handshakes
// depends on gwrc_pkg, gwrc_cfg_regs, gwrc_axis_map, gwrc_mode_ctrl
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   input   | in        | in_valid_i/in_stall_o   | in_item_i  (in_item_t)
//   result  | out       | out_valid_o/out_stall_i | out_item_o (out_item_t)
//   config  | in        | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// one frame per cycle sustained while the result is not stalled; a frame passes through the
// input register, then the result register, with the mode logic between them
// the frame state advances as a frame moves from the input to the result register
// reset clears the mode state and loads the register defaults
// a stalled result holds; the input register keeps taking frames while the result is free

module gamepad_to_wii_report_converter import gwrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  axis_t     axis;
  out_item_t res;
  in_item_t  in_q;
  out_item_t out_q;
  logic      in_valid_q, out_valid_q;
  logic      step, take;

  gwrc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gwrc_axis_map u_axis (
    .item_i     (in_q),
    .deadzone_i (cfg.deadzone),
    .axis_o     (axis)
  );

  gwrc_mode_ctrl u_mode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .axis_i (axis),
    .res_o  (res)
  );

  // handshake: result register frees when empty or taken
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign take       = in_valid_i && !in_stall_o;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_item_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
